// File: hdl/fsk_pkg.sv
package fsk_pkg;

  localparam int SineTableBits = 10;
  localparam int PhaseBits     = 32;
  localparam int TimerBits     = 20;

  localparam int TableLen   = 1 << SineTableBits;
  localparam int QuarterLen = TableLen >> 2;

  localparam int CharW     = 8;
  localparam int BitIdxW   = 3;
  localparam int RomW      = 16;
  localparam int AmpW      = 12;
  localparam int SampleW   = 12;
  localparam int ChanW     = 5;
  localparam int FrameW    = 24;
  localparam int ChanLsb   = 19;
  localparam int FrameGapW = ChanLsb - SampleW;
  localparam int ProductW  = RomW + AmpW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  localparam logic [BitIdxW-1:0] BitIdxFirst = 3'd7;
  localparam logic [BitIdxW-1:0] BitIdxLast  = 3'd0;
  localparam logic [RomW-1:0]    SignFlip    = 16'h8000;

  localparam logic [TimerBits-1:0] TicksPerBitReset = 20'd10000;
  localparam logic [AmpW-1:0]      AmplitudeReset   = 12'd409;

  // Quarter turn in Q30 radians.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_STEP_HIGH = 3'd0,
    CFG_PHASE_STEP_LOW  = 3'd1,
    CFG_TICKS_PER_BIT   = 3'd2,
    CFG_AMPLITUDE       = 3'd3,
    CFG_DAC_CHANNEL     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PhaseBits-1:0] phase_step_high;
    logic [PhaseBits-1:0] phase_step_low;
    logic [TimerBits-1:0] ticks_per_bit;
    logic [AmpW-1:0]      amplitude;
    logic [ChanW-1:0]     dac_channel;
  } cfg_t;

  typedef struct packed {
    logic taken;
    logic act;
    logic done;
  } tick_info_t;

  typedef logic [TableLen-1:0][RomW-1:0] sine_rom_t;

  // Two multiplications by the angle in Q30, used for each Taylor term.
  function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // First-quadrant sine in Q15 for table position m of a quarter turn.
  function automatic logic [RomW-1:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q15;
    x    = (m * HalfPiQ30) >> (SineTableBits - 2);
    term = x;
    sum  = x;
    term = sq_step(term, x) / 64'd6;
    sum  = sum - term;
    term = sq_step(term, x) / 64'd20;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd42;
    sum  = sum - term;
    term = sq_step(term, x) / 64'd72;
    sum  = sum + term;
    term = sq_step(term, x) / 64'd110;
    sum  = sum - term;
    q15  = (sum + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return q15[RomW-1:0];
  endfunction

  // Full-cycle table built from the first quadrant by symmetry.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [1:0] quad;
    logic [63:0] r;
    logic [RomW-1:0] mag;
    for (int k = 0; k < TableLen; k++) begin
      quad = 2'(k >> (SineTableBits - 2));
      r    = 64'(k) & 64'(QuarterLen - 1);
      mag  = quad[0] ? quarter_sine(64'(QuarterLen) - r) : quarter_sine(r);
      rom[k] = (quad[1] && (mag != '0)) ? (~mag + 16'd1) : mag;
    end
    return rom;
  endfunction

endpackage

// File: hdl/fsk_sine_rom.sv
module fsk_sine_rom
  import fsk_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [SineTableBits-1:0] addr,
  output logic [RomW-1:0]          data_r
);

  localparam sine_rom_t SineRom = build_sine_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= SineRom[addr];
    end
  end

endmodule

// File: hdl/fsk_bit_seq.sv
module fsk_bit_seq
  import fsk_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     load_valid,
  input  logic [CharW-1:0]         char_in,
  input  cfg_t                     cfg,
  output logic [SineTableBits-1:0] rom_addr,
  output tick_info_t               info_r
);

  logic [CharW-1:0]     shift_byte_r, shift_byte_nxt;
  logic [BitIdxW-1:0]   bit_index_r, bit_index_nxt;
  logic [TimerBits-1:0] bit_timer_r, bit_timer_nxt;
  logic [PhaseBits-1:0] phase_acc_r, phase_acc_nxt;
  logic                 busy_r, busy_nxt;
  tick_info_t           info_nxt;

  logic                 start;
  logic                 run;
  logic [CharW-1:0]     cur_byte;
  logic [BitIdxW-1:0]   cur_idx;
  logic [TimerBits-1:0] cur_timer;
  logic [PhaseBits-1:0] cur_phase;
  logic [PhaseBits-1:0] step;
  logic [TimerBits-1:0] limit_m1;
  logic                 bit_end;

  always_comb begin
    start     = load_valid && !busy_r;
    run       = busy_r || start;
    // A load tick is already the first tick of the first bit, at phase zero.
    cur_byte  = start ? char_in : shift_byte_r;
    cur_idx   = start ? BitIdxFirst : bit_index_r;
    cur_timer = start ? '0 : bit_timer_r;
    cur_phase = start ? '0 : phase_acc_r;
    step      = cur_byte[cur_idx] ? cfg.phase_step_high : cfg.phase_step_low;
    rom_addr  = cur_phase[PhaseBits-1 -: SineTableBits];
    // A zero bit length counts as one tick.
    limit_m1  = (cfg.ticks_per_bit == '0) ? '0 : cfg.ticks_per_bit - 1'b1;
    bit_end   = cur_timer >= limit_m1;
  end

  always_comb begin
    shift_byte_nxt = shift_byte_r;
    bit_index_nxt  = bit_index_r;
    bit_timer_nxt  = bit_timer_r;
    phase_acc_nxt  = phase_acc_r;
    busy_nxt       = busy_r;
    info_nxt.taken = start;
    info_nxt.act   = run;
    info_nxt.done  = 1'b0;
    if (run) begin
      shift_byte_nxt = cur_byte;
      busy_nxt       = 1'b1;
      if (bit_end) begin
        bit_timer_nxt = '0;
        phase_acc_nxt = '0;
        if (cur_idx == BitIdxLast) begin
          busy_nxt      = 1'b0;
          bit_index_nxt = BitIdxFirst;
          info_nxt.done = 1'b1;
        end else begin
          bit_index_nxt = cur_idx - 1'b1;
        end
      end else begin
        bit_index_nxt = cur_idx;
        bit_timer_nxt = cur_timer + 1'b1;
        phase_acc_nxt = cur_phase + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_byte_r <= '0;
      bit_index_r  <= BitIdxFirst;
      bit_timer_r  <= '0;
      phase_acc_r  <= '0;
      busy_r       <= 1'b0;
      info_r       <= '0;
    end else if (accept) begin
      shift_byte_r <= shift_byte_nxt;
      bit_index_r  <= bit_index_nxt;
      bit_timer_r  <= bit_timer_nxt;
      phase_acc_r  <= phase_acc_nxt;
      busy_r       <= busy_nxt;
      info_r       <= info_nxt;
    end
  end

`ifndef SYNTH
  a_idle_index_reset : assert property (@(posedge clk) disable iff (!rst_n)
    (bit_index_r != BitIdxFirst) |-> busy_r)
    else $error("bit index left the first bit while idle");

  a_taken_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !busy_r && load_valid) |=> (busy_r && info_r.taken))
    else $error("accepted character did not start a transmission");

  a_busy_ends_done : assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy_r) && $past(rst_n)) |-> info_r.done)
    else $error("transmission ended without a done flag");
`endif

endmodule

// File: hdl/fsk_out_stage.sv
module fsk_out_stage
  import fsk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              out_stall,
  input  tick_info_t        info,
  input  logic [RomW-1:0]   rom_data,
  input  logic [AmpW-1:0]   amplitude,
  input  logic [ChanW-1:0]  dac_channel,
  output logic              out_valid,
  output logic              out_load_taken,
  output logic              out_active,
  output logic [SampleW-1:0] out_sample,
  output logic [FrameW-1:0] out_dac_frame,
  output logic              out_char_done
);

  logic                 valid_r;
  tick_info_t           flags_r;
  logic [SampleW-1:0]   sample_r;
  logic [RomW-1:0]      offs;
  logic [ProductW-1:0]  product;

  always_comb begin
    // Flipping the sign bit turns the two's complement value into offset binary.
    offs    = rom_data ^ SignFlip;
    product = ProductW'(offs) * ProductW'(amplitude);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      flags_r  <= '0;
      sample_r <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      flags_r <= info;
      // Idle ticks hold the previous sample.
      if (info.act) begin
        sample_r <= product[ProductW-1 -: SampleW];
      end
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid      = valid_r;
  assign out_load_taken = flags_r.taken;
  assign out_active     = flags_r.act;
  assign out_char_done  = flags_r.done;
  assign out_sample     = sample_r;
  assign out_dac_frame  = {dac_channel, {FrameGapW{1'b0}}, sample_r};

endmodule

// File: hdl/fsk_tone_transmitter.sv
// Binary FSK tone transmitter. Each input transfer is one microsecond tick and
// produces exactly one result transfer carrying a 12-bit DAC sample and the
// matching 24-bit DAC frame. A tick with in_load_valid set starts an eight-bit
// character, MSB first, if no character is in progress (out_load_taken reports
// it); each bit runs ticks_per_bit ticks with the phase accumulator restarted at
// zero. While out_stall stays low one tick is accepted every clock cycle. The
// bit sequencer and the registered read of the 1024-entry sine ROM form the
// first stage, written at the edge that accepts a tick; the amplitude
// multiplier then fills the result register. A stalled result holds, and the
// input stalls only when both the first stage and the result register are
// full. The user must write registers through the cfg port only while no tick
// is in flight; the block itself does not enforce this.
module fsk_tone_transmitter
  import fsk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_load_valid,
  input  logic [CharW-1:0]    in_char_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_load_taken,
  output logic                out_active,
  output logic [SampleW-1:0]  out_sample,
  output logic [FrameW-1:0]   out_dac_frame,
  output logic                out_char_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t                     cfg_r;
  logic                     s1_valid_r;
  logic                     in_accept;
  logic                     out_load;
  logic [SineTableBits-1:0] rom_addr;
  logic [RomW-1:0]          rom_data;
  tick_info_t               s1_info;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step_high <= '0;
      cfg_r.phase_step_low  <= '0;
      cfg_r.ticks_per_bit   <= TicksPerBitReset;
      cfg_r.amplitude       <= AmplitudeReset;
      cfg_r.dac_channel     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_STEP_HIGH: cfg_r.phase_step_high <= cfg_data[PhaseBits-1:0];
        CFG_PHASE_STEP_LOW:  cfg_r.phase_step_low  <= cfg_data[PhaseBits-1:0];
        CFG_TICKS_PER_BIT:   cfg_r.ticks_per_bit   <= cfg_data[TimerBits-1:0];
        CFG_AMPLITUDE:       cfg_r.amplitude       <= cfg_data[AmpW-1:0];
        CFG_DAC_CHANNEL:     cfg_r.dac_channel     <= cfg_data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // The first stage moves on whenever the result register is free or is being emptied.
  assign out_load  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  fsk_bit_seq u_bit_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .load_valid (in_load_valid),
    .char_in    (in_char_in),
    .cfg        (cfg_r),
    .rom_addr   (rom_addr),
    .info_r     (s1_info)
  );

  fsk_sine_rom u_sine_rom (
    .clk    (clk),
    .en     (in_accept),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  fsk_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (out_load),
    .out_stall      (out_stall),
    .info           (s1_info),
    .rom_data       (rom_data),
    .amplitude      (cfg_r.amplitude),
    .dac_channel    (cfg_r.dac_channel),
    .out_valid      (out_valid),
    .out_load_taken (out_load_taken),
    .out_active     (out_active),
    .out_sample     (out_sample),
    .out_dac_frame  (out_dac_frame),
    .out_char_done  (out_char_done)
  );

`ifndef SYNTH
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  a_stage_drains : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid) |=> out_valid)
    else $error("first stage did not move into a free result register");

  a_no_loss : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load && !in_accept) |=> s1_valid_r)
    else $error("first stage dropped a tick");
`endif

endmodule

// File: dv/fsk_tone_transmitter_test.sv
`timescale 1ns / 1ps

module fsk_tone_transmitter_test;
  import fsk_pkg::*;

  localparam int unsigned RandomTicks = 2000;
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [TimerBits-1:0] LongestBit = '1;
  // An index with no register behind it; a write there must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  typedef struct packed {
    logic               taken;
    logic               act;
    logic [SampleW-1:0] sample;
    logic [FrameW-1:0]  frame;
    logic               done;
  } tick_result_t;

  class fsk_scoreboard;
    logic [PhaseBits-1:0] step_one;
    logic [PhaseBits-1:0] step_zero;
    logic [TimerBits-1:0] bit_ticks;
    logic [AmpW-1:0]      amp;
    logic [ChanW-1:0]     chan;

    logic [CharW-1:0]     char_reg;
    logic [BitIdxW-1:0]   bit_pos;
    logic [TimerBits-1:0] tick_cnt;
    logic [PhaseBits-1:0] phase;
    bit                   sending;
    logic [SampleW-1:0]   held_sample;

    logic [RomW-1:0] sine_rom [TableLen];
    tick_result_t expected [$];
    int unsigned errors, ticks, results, chars_started, chars_done;

    function new();
      logic [RomW-1:0] mag;
      int unsigned quad, r;
      step_one    = '0;
      step_zero   = '0;
      bit_ticks   = TicksPerBitReset;
      amp         = AmplitudeReset;
      chan        = '0;
      char_reg    = '0;
      bit_pos     = 3'd7;
      tick_cnt    = '0;
      phase       = '0;
      sending     = 1'b0;
      held_sample = '0;
      for (int k = 0; k < TableLen; k++) begin
        quad = k / QuarterLen;
        r    = k % QuarterLen;
        mag  = quad[0] ? quarter_q15(QuarterLen - r) : quarter_q15(r);
        sine_rom[k] = (quad[1] && mag != '0) ? 16'h0 - mag : mag;
      end
    endfunction

    // Taylor series of the sine to the eleventh power, every term truncated in Q30.
    function logic [RomW-1:0] quarter_q15(int unsigned m);
      longint unsigned x, term, sum, q15;
      x    = (longint'(m) * HalfPiQ30) / QuarterLen;
      term = x;
      sum  = x;
      for (int n = 1; n <= 5; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q15 = (sum + 64'd16384) >> 15;
      if (q15 > 64'd32767) begin
        q15 = 64'd32767;
      end
      return q15[RomW-1:0];
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_PHASE_STEP_HIGH: step_one  = val[PhaseBits-1:0];
        CFG_PHASE_STEP_LOW:  step_zero = val[PhaseBits-1:0];
        CFG_TICKS_PER_BIT:   bit_ticks = val[TimerBits-1:0];
        CFG_AMPLITUDE:       amp       = val[AmpW-1:0];
        CFG_DAC_CHANNEL:     chan      = val[ChanW-1:0];
        default: ;
      endcase
    endfunction

    // Advances the modulator by one accepted tick and queues the sample it yields.
    function void note_tick(logic load, logic [CharW-1:0] ch);
      tick_result_t want;
      logic [PhaseBits-1:0] step;
      logic [RomW-1:0]      offs;
      logic [ProductW-1:0]  prod;
      logic [TimerBits:0]   limit;
      want  = '0;
      ticks = ticks + 1;
      if (load && !sending) begin
        sending    = 1'b1;
        want.taken = 1'b1;
        char_reg   = ch;
        bit_pos    = 3'd7;
        tick_cnt   = '0;
        phase      = '0;
        chars_started = chars_started + 1;
      end
      if (sending) begin
        step        = char_reg[bit_pos] ? step_one : step_zero;
        offs        = sine_rom[phase[PhaseBits-1 -: SineTableBits]] ^ SignFlip;
        prod        = offs * amp;
        held_sample = prod[ProductW-1 -: SampleW];
        phase       = phase + step;
        want.act    = 1'b1;
        // A zero bit length behaves as one tick per bit.
        limit = (bit_ticks == '0) ? (TimerBits + 1)'(1) : {1'b0, bit_ticks};
        if ({1'b0, tick_cnt} + 1 >= limit) begin
          tick_cnt = '0;
          phase    = '0;
          if (bit_pos == 3'd0) begin
            want.done  = 1'b1;
            sending    = 1'b0;
            bit_pos    = 3'd7;
            chars_done = chars_done + 1;
          end else begin
            bit_pos = bit_pos - 1'b1;
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      want.sample = held_sample;
      want.frame  = {chan, {FrameGapW{1'b0}}, held_sample};
      expected.push_back(want);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        errors = errors + 1;
      end
    endfunction

    function void check(tick_result_t got);
      tick_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: result transfer with nothing expected, got sample 0x%0h",
                 $time, got.sample);
        errors = errors + 1;
        return;
      end
      want    = expected.pop_front();
      results = results + 1;
      compare_field("load_taken", want.taken, got.taken);
      compare_field("active", want.act, got.act);
      compare_field("sample", want.sample, got.sample);
      compare_field("dac_frame", want.frame, got.frame);
      compare_field("char_done", want.done, got.done);
    endfunction
  endclass

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic                in_load_valid = 1'b0;
  logic [CharW-1:0]    in_char_in    = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic                out_load_taken;
  logic                out_active;
  logic [SampleW-1:0]  out_sample;
  logic [FrameW-1:0]   out_dac_frame;
  logic                out_char_done;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  fsk_scoreboard board;
  tick_result_t  seen;
  int unsigned   cycles = 0;
  logic [1:0]    stall_mode = 2'd0;
  int unsigned   stall_left = 0;

  fsk_tone_transmitter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_load_valid  (in_load_valid),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_load_taken (out_load_taken),
    .out_active     (out_active),
    .out_sample     (out_sample),
    .out_dac_frame  (out_dac_frame),
    .out_char_done  (out_char_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver switches between no stalls, light, heavy and alternating stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 128);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.taken  = out_load_taken;
      seen.act    = out_active;
      seen.sample = out_sample;
      seen.frame  = out_dac_frame;
      seen.done   = out_char_done;
      board.check(seen);
    end
  end

  // Leaves in_valid high on return so that a burst runs without a gap.
  task automatic send_tick(input logic load, input logic [CharW-1:0] ch);
    in_valid      <= 1'b1;
    in_load_valid <= load;
    in_char_in    <= ch;
    do @(posedge clk); while (in_stall);
    board.note_tick(load, ch);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  // Waits until every tick in flight has produced its result transfer.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_ticks, burst, gap, phase_no;
    bit long_bit;
    logic [CfgDataW-1:0] bit_len;

    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle ticks under reset settings: the held sample must still be zero.
    send_tick(1'b0, 8'hFF);
    send_tick(1'b0, 8'h00);
    drain();

    write_reg(CFG_PHASE_STEP_HIGH, 32'hFFFF_FFFF);
    write_reg(CFG_PHASE_STEP_LOW, 32'h0);
    write_reg(CFG_TICKS_PER_BIT, 32'h0);
    write_reg(CFG_AMPLITUDE, 32'd4095);
    write_reg(CFG_DAC_CHANNEL, 32'd31);
    write_reg(CfgIdxSpare, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;

    // One tick per bit: loads offered while busy are refused, and a load on
    // the tick after the last bit is taken at once.
    send_tick(1'b1, 8'hA5);
    for (int n = 0; n < 7; n++) begin
      send_tick(1'b1, 8'h5A);
    end
    send_tick(1'b1, 8'h00);
    for (int n = 0; n < 7; n++) begin
      send_tick(1'b0, 8'hFF);
    end
    send_tick(1'b0, 8'h00);
    drain();

    random_ticks = 0;
    phase_no     = 0;
    long_bit     = 1'b0;
    while (random_ticks < RandomTicks) begin
      phase_no = phase_no + 1;
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_PHASE_STEP_HIGH, pick_step());
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_PHASE_STEP_LOW, pick_step());
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       write_reg(CFG_AMPLITUDE, 32'd0);
          1:       write_reg(CFG_AMPLITUDE, 32'd4095);
          default: write_reg(CFG_AMPLITUDE, $urandom);
        endcase
      end
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_DAC_CHANNEL, $urandom);
      end
      // Every sixth phase sends with the longest bit; the phase after it
      // shortens the bit mid-character so that the running bit can end at once.
      if (phase_no % 6 == 3) begin
        write_reg(CFG_TICKS_PER_BIT, 32'(LongestBit));
        long_bit = 1'b1;
      end else if (long_bit || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       bit_len = 32'd0;
          1:       bit_len = $urandom_range(10, 40);
          default: bit_len = $urandom_range(1, 6);
        endcase
        write_reg(CFG_TICKS_PER_BIT, bit_len);
        long_bit = 1'b0;
      end
      cfg_valid <= 1'b0;

      for (int unsigned span = long_bit ? 40 : $urandom_range(20, 200); span > 0; ) begin
        burst = $urandom_range(1, 30);
        if (burst > span) begin
          burst = span;
        end
        for (int unsigned n = 0; n < burst; n++) begin
          send_tick(1'($urandom_range(0, 1)), 8'($urandom));
        end
        span         = span - burst;
        random_ticks = random_ticks + burst;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d ticks over %0d setting phases; %0d results checked.",
             board.ticks, phase_no, board.results);
    $display("Characters started: %0d, completed: %0d.",
             board.chars_started, board.chars_done);
    if (board.errors == 0 && board.expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
